[src/rlte_pkg.sv]
package rlte_pkg;

   // Longest run that the decimal count can express in two digits
   localparam logic [6:0] RUN_CAP = 7'd99;
   localparam logic [6:0] MAX_RUN_RESET = 7'd99;

   // Reciprocal of ten for the tens digit: (len * 205) >> 11 is exact for len < 128
   localparam logic [7:0] TENTH_MUL = 8'd205;
   localparam int TENTH_SHIFT = 11;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   // Position within one emitted run: tens digit, units digit, run byte
   localparam logic [1:0] POS_TENS  = 2'd0;
   localparam logic [1:0] POS_UNITS = 2'd1;
   localparam logic [1:0] POS_BYTE  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
   } rsp_type;

   // One closed run, ready to be sent as text
   typedef struct packed {
      logic [7:0] run_byte;
      logic [3:0] tens;
      logic [3:0] units;
      logic       two_digit;
   } run_rec_type;

   // Split a run length (at most 99) into its decimal digits
   function automatic run_rec_type make_rec(logic [7:0] byte_val, logic [6:0] len);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [7:0]  tens_x10;
      run_rec_type rec;
      prod      = {8'd0, len} * {7'd0, TENTH_MUL};
      tens      = prod[TENTH_SHIFT +: 4];
      tens_x10  = {tens, 3'd0} + {3'd0, tens, 1'b0};
      rec.run_byte  = byte_val;
      rec.tens      = tens;
      rec.units     = 4'({1'b0, len} - tens_x10);
      rec.two_digit = (tens != 4'd0);
      return rec;
   endfunction

   // First position to send for a record
   function automatic logic [1:0] first_pos(run_rec_type rec);
      return rec.two_digit ? POS_TENS : POS_UNITS;
   endfunction

endpackage

[src/run_length_text_encoder.sv]
// Run-length text encoder. Each run of equal input bytes leaves as its length in
// ASCII decimal (no leading zeros) followed by the byte itself; a run closes when a
// different byte arrives or when it reaches csr max_run (0 acts as 1, above 99 as 99),
// and a request with end_of_stream set also flushes the open run. The run state is
// updated in the cycle a request is taken, so requests that only extend a run can
// follow back to back while no earlier result is being sent. The single byte-wide
// result port sets the rate otherwise: a request that closes a run emits two or three
// bytes, up to six at end of stream. The next request is taken in the cycle the final
// byte of the previous one is taken. last_of_item marks each request's final byte.
module run_length_text_encoder #(
   parameter logic [6:0] MAX_RUN_RESET = rlte_pkg::MAX_RUN_RESET
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rlte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rlte_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data
);

   // Configuration and run state
   logic [6:0] max_run_ff;
   logic [7:0] run_byte_ff, run_byte_in;
   logic [6:0] run_length_ff, run_length_in;
   logic       run_open_ff, run_open_in;

   // Result buffer: a closed run (A) and a flushed run (B)
   rlte_pkg::run_rec_type rec_a_ff, rec_a_in, rec_b_ff, rec_b_in;
   logic       has_a_ff, has_a_in;
   logic       has_b_ff, has_b_in;
   logic       busy_ff, busy_in;
   logic       seg_b_ff, seg_b_in;
   logic [1:0] pos_ff, pos_in;

   logic       req_fire, rsp_fire;
   logic [6:0] limit;
   logic       extend;
   logic [7:0] new_byte;
   logic [6:0] new_length;
   rlte_pkg::run_rec_type cur_rec;
   logic       cur_last;
   logic [7:0] cur_byte;

   // Effective run limit
   always_comb begin
      if (max_run_ff == 7'd0) begin
         limit = 7'd1;
      end else if (max_run_ff > rlte_pkg::RUN_CAP) begin
         limit = rlte_pkg::RUN_CAP;
      end else begin
         limit = max_run_ff;
      end
   end

   // Output side
   assign cur_rec  = seg_b_ff ? rec_b_ff : rec_a_ff;
   assign cur_last = (pos_ff == rlte_pkg::POS_BYTE) && (seg_b_ff || !has_b_ff);

   always_comb begin
      case (pos_ff)
         rlte_pkg::POS_TENS:  cur_byte = rlte_pkg::ASCII_ZERO | {4'd0, cur_rec.tens};
         rlte_pkg::POS_UNITS: cur_byte = rlte_pkg::ASCII_ZERO | {4'd0, cur_rec.units};
         default:             cur_byte = cur_rec.run_byte;
      endcase
   end

   assign rsp_valid             = busy_ff;
   assign rsp_data.out_byte     = cur_byte;
   assign rsp_data.last_of_item = cur_last;
   assign rsp_fire              = busy_ff && rsp_ready;

   assign req_ready = !busy_ff || (rsp_ready && cur_last);
   assign req_fire  = req_valid && req_ready;

   // Run tracking for the incoming request
   always_comb begin
      extend = run_open_ff && (req_data.data_byte == run_byte_ff) && (run_length_ff < limit);
      if (extend) begin
         new_byte   = run_byte_ff;
         new_length = run_length_ff + 7'd1;
      end else begin
         new_byte   = req_data.data_byte;
         new_length = 7'd1;
      end
      rec_a_in = rlte_pkg::make_rec(run_byte_ff, run_length_ff);
      rec_b_in = rlte_pkg::make_rec(new_byte, new_length);
      has_a_in = run_open_ff && !extend;
      has_b_in = req_data.end_of_stream;
      if (req_data.end_of_stream) begin
         run_byte_in   = 8'd0;
         run_length_in = 7'd0;
         run_open_in   = 1'b0;
      end else begin
         run_byte_in   = new_byte;
         run_length_in = new_length;
         run_open_in   = 1'b1;
      end
   end

   // Serialiser control
   always_comb begin
      busy_in  = busy_ff;
      seg_b_in = seg_b_ff;
      pos_in   = pos_ff;
      if (rsp_fire) begin
         if (pos_ff != rlte_pkg::POS_BYTE) begin
            pos_in = pos_ff + 2'd1;
         end else if (!seg_b_ff && has_b_ff) begin
            seg_b_in = 1'b1;
            pos_in   = rlte_pkg::first_pos(rec_b_ff);
         end else begin
            busy_in = 1'b0;
         end
      end
      if (req_fire) begin
         busy_in  = has_a_in || has_b_in;
         seg_b_in = !has_a_in;
         pos_in   = has_a_in ? rlte_pkg::first_pos(rec_a_in) : rlte_pkg::first_pos(rec_b_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff    <= MAX_RUN_RESET;
         run_byte_ff   <= 8'd0;
         run_length_ff <= 7'd0;
         run_open_ff   <= 1'b0;
         busy_ff       <= 1'b0;
         seg_b_ff      <= 1'b0;
         pos_ff        <= rlte_pkg::POS_TENS;
         has_a_ff      <= 1'b0;
         has_b_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_run_ff <= csr_write_data;
         end
         busy_ff  <= busy_in;
         seg_b_ff <= seg_b_in;
         pos_ff   <= pos_in;
         if (req_fire) begin
            run_byte_ff   <= run_byte_in;
            run_length_ff <= run_length_in;
            run_open_ff   <= run_open_in;
            has_a_ff      <= has_a_in;
            has_b_ff      <= has_b_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rec_a_ff <= rec_a_in;
         rec_b_ff <= rec_b_in;
      end
   end

   // Assertions
   a_seg_b_has_b: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && seg_b_ff) |-> has_b_ff)
      else $error("sending flushed run that was never loaded");

   a_seg_a_has_a: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !seg_b_ff) |-> has_a_ff)
      else $error("sending closed run that was never loaded");

   a_eos_emits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.end_of_stream) |=> (busy_ff && !run_open_ff))
      else $error("end of stream did not flush the run");

   a_hold_until_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cur_last) |-> !req_ready)
      else $error("request taken before previous results were sent");

endmodule

[tb/run_length_text_encoder_tb.sv]
`timescale 1ns / 1ps

module run_length_text_encoder_tb;

   // Quiet cycles allowed after the last output byte before a register write
   localparam int DRAIN_CYCLES = 12;
   localparam int TIMEOUT_NS = 5_000_000;

   // Predicts the encoded text for each request and checks the output bytes
   class rle_scoreboard;
      logic [7:0]        held_byte;
      logic [6:0]        held_len;
      bit                held_open;
      logic [6:0]        max_run_reg;
      rlte_pkg::rsp_type text_q[$];
      int                errors;
      int                requests_seen;
      int                bytes_checked;
      int                streams_closed;

      function new();
         max_run_reg    = rlte_pkg::MAX_RUN_RESET;
         held_byte      = 8'd0;
         held_len       = 7'd0;
         held_open      = 1'b0;
         errors         = 0;
         requests_seen  = 0;
         bytes_checked  = 0;
         streams_closed = 0;
      endfunction

      function void set_max_run(logic [6:0] value);
         max_run_reg = value;
      endfunction

      function int pending();
         return text_q.size();
      endfunction

      // Count as decimal text without leading zeros, then the run byte
      function void append_run(ref rlte_pkg::rsp_type run_text[$]);
         logic [6:0]        len;
         rlte_pkg::rsp_type item;
         len = (held_len > rlte_pkg::RUN_CAP) ? rlte_pkg::RUN_CAP : held_len;
         item.last_of_item = 1'b0;
         if (len >= 7'd10) begin
            item.out_byte = rlte_pkg::ASCII_ZERO + 8'(len / 7'd10);
            run_text.push_back(item);
         end
         item.out_byte = rlte_pkg::ASCII_ZERO + 8'(len % 7'd10);
         run_text.push_back(item);
         item.out_byte = held_byte;
         run_text.push_back(item);
      endfunction

      function void note_request(rlte_pkg::req_type req);
         logic [6:0]        limit;
         rlte_pkg::rsp_type run_text[$];
         requests_seen++;
         limit = max_run_reg;
         if (limit == 7'd0)
            limit = 7'd1;
         if (limit > rlte_pkg::RUN_CAP)
            limit = rlte_pkg::RUN_CAP;

         // extend the open run, or close it and start a new one
         if (held_open && req.data_byte == held_byte && held_len < limit) begin
            held_len++;
         end else begin
            if (held_open)
               append_run(run_text);
            held_byte = req.data_byte;
            held_len  = 7'd1;
            held_open = 1'b1;
         end

         // end of stream flushes whatever is held
         if (req.end_of_stream) begin
            append_run(run_text);
            held_open = 1'b0;
            held_len  = 7'd0;
            held_byte = 8'd0;
            streams_closed++;
         end

         if (run_text.size() > 0)
            run_text[run_text.size() - 1].last_of_item = 1'b1;
         foreach (run_text[i])
            text_q.push_back(run_text[i]);
      endfunction

      function void check_response(rlte_pkg::rsp_type actual);
         rlte_pkg::rsp_type exp;
         bytes_checked++;
         if (text_q.size() == 0) begin
            $display("%0t: unexpected output byte %h last %b", $time,
                     actual.out_byte, actual.last_of_item);
            errors++;
            return;
         end
         exp = text_q.pop_front();
         if (actual.out_byte !== exp.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     exp.out_byte, actual.out_byte);
            errors++;
         end
         if (actual.last_of_item !== exp.last_of_item) begin
            $display("%0t: last_of_item expected %b actual %b", $time,
                     exp.last_of_item, actual.last_of_item);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rlte_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rlte_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic [6:0]        csr_write_data;

   rle_scoreboard sb = new();
   int send_idle_pct = 23;
   int recv_idle_pct = 61;
   int settings_used = 1;

   run_length_text_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Handshakes sampled at the rising edge; request noted first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_data);
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // One request: optional idle cycles, then hold until taken
   task automatic send_request(input logic [7:0] value, input logic eos);
      rlte_pkg::req_type req;
      req.data_byte     = value;
      req.end_of_stream = eos;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Register write once all output has drained
   task automatic write_max_run(input logic [6:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_max_run(value);
      settings_used++;
   endtask

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly runs of random length (up to 12, or up to two past the limit), some noise and lone flushes
   task automatic run_phase(input int n_items, input int limit);
      int         left;
      int         len;
      int         kind;
      logic [7:0] value;
      bit         close_it;
      left = n_items;
      while (left > 0) begin
         kind  = $urandom_range(0, 9);
         value = pick_byte();
         if (kind <= 6) begin
            if ($urandom_range(0, 3) == 0)
               len = $urandom_range(1, limit + 2);
            else
               len = $urandom_range(1, 12);
            close_it = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
               send_request(value, close_it && (i == len - 1));
            left -= len;
         end else if (kind <= 8) begin
            send_request(value, $urandom_range(0, 7) == 0);
            left--;
         end else begin
            send_request(value, 1'b1);
            left--;
         end
      end
   endtask

   initial begin
      logic [6:0] setting;
      int         limit;
      logic [7:0] value;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: flush with nothing held, NUL and all-ones bytes,
      // one- to two-digit boundary, limit lowered under an open run, saturation
      send_request(8'h41, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b1);
      repeat (9) send_request(8'h55, 1'b0);
      send_request(8'h55, 1'b1);
      repeat (4) send_request(8'h33, 1'b0);
      write_max_run(7'd2);
      send_request(8'h33, 1'b1);
      repeat (4) send_request(8'h7A, 1'b0);
      send_request(8'h7A, 1'b1);

      // Random phases over several limits, including zero and above the cap
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: setting = 7'd1;
            1: setting = 7'd0;
            2: setting = 7'd127;
            3: setting = 7'd2;
            4: setting = 7'd10;
            5: setting = 7'($urandom_range(1, 99));
            6: setting = 7'd100;
            default: setting = 7'd99;
         endcase
         if (p == 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 23;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_max_run(setting);
         limit = (setting == 7'd0) ? 1 : ((setting > 7'd99) ? 99 : int'(setting));
         if (p == 7) begin
            // one run well past the cap
            value = pick_byte();
            repeat (101) send_request(value, 1'b0);
            send_request(value, 1'b1);
         end
         run_phase((p >= 6) ? 40 : 30, limit);
      end
      send_request(pick_byte(), 1'b1);
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Covered %0d requests and %0d output bytes, %0d streams closed,",
               sb.requests_seen, sb.bytes_checked, sb.streams_closed);
      $display("over %0d max_run settings with varied back-pressure; %0d errors",
               settings_used, sb.errors);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule
